// ===== hdl/bounded_deque_with_indexed_removal_assert.svh =====
// assertion macros used by the checker file
`ifndef BOUNDED_DEQUE_WITH_INDEXED_REMOVAL_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_REMOVAL_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BDQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bdq_pkg.sv =====
// shared constants, codes and types of the bounded deque
package bdq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // port field widths
   localparam int KIND_W   = 3;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 4;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // width used to compare a position against the fill count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [KIND_W-1:0] {
      K_PUSH_BACK  = 3'd0,
      K_PUSH_FRONT = 3'd1,
      K_POP_BACK   = 3'd2,
      K_POP_FRONT  = 3'd3,
      K_REMOVE     = 3'd4,
      K_FIND       = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic emit;
   } cmd_type;

endpackage

// ===== hdl/bdq_ctrl.sv =====
// sequencer for the deque: capture, execute, emit, plus the result valid flag
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdq_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_comb begin
      slot_free   = !rsp_valid_ff || rsp_ready;
      req_ready   = (state_ff == S_IDLE);
      cmd.capture = req_valid && (state_ff == S_IDLE);
      cmd.exec    = (state_ff == S_EXEC);
      cmd.emit    = (state_ff == S_EMIT) && slot_free;
      state_in    = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/bdq_dp.sv =====
// datapath: entry cells, fill count, compare row and result registers
module bdq_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  bdq_pkg::cmd_type                cmd,
   input  logic [bdq_pkg::KIND_W-1:0]      req_kind,
   input  logic [bdq_pkg::VAL_W-1:0]       req_item_value,
   input  logic [bdq_pkg::POS_W-1:0]       req_position,
   output logic [bdq_pkg::VAL_W-1:0]       rsp_out_value,
   output logic [bdq_pkg::INDEX_W-1:0]     rsp_out_index,
   output logic [bdq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]     rsp_count
);

   // captured transaction
   bdq_pkg::kind_type                   kind_ff;
   logic [bdq_pkg::VALUE_WIDTH-1:0]     key_ff;
   logic [bdq_pkg::POS_W-1:0]           pos_ff;

   // list state
   logic [bdq_pkg::VALUE_WIDTH-1:0]     entries_ff [bdq_pkg::DEPTH];
   logic [bdq_pkg::VALUE_WIDTH-1:0]     entries_in [bdq_pkg::DEPTH];
   logic [bdq_pkg::CNT_W-1:0]           count_ff, count_in;

   // intermediate results between execute and emit
   logic [bdq_pkg::VALUE_WIDTH-1:0]     res_val_ff, res_val_in;
   bdq_pkg::status_type                 status_ff, status_in;
   logic [bdq_pkg::DEPTH-1:0]           match_ff, match_in;

   // output registers
   logic [bdq_pkg::VAL_W-1:0]           out_value_ff;
   logic [bdq_pkg::INDEX_W-1:0]         out_index_ff;
   bdq_pkg::status_type                 out_status_ff, out_status_in;
   logic [bdq_pkg::COUNT_W-1:0]         out_count_ff;

   logic                                full, empty, pos_bad, take;
   logic [bdq_pkg::IDX_W-1:0]           rd_idx, find_idx;
   logic [bdq_pkg::VALUE_WIDTH-1:0]     rd_data;
   logic [bdq_pkg::DEPTH-1:0]           match_vec;

   // single read port for pops and removal, plus the status flags and find compare row
   always_comb begin
      full    = (count_ff >= bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
      empty   = (count_ff == '0);
      pos_bad = (bdq_pkg::CMP_W'(pos_ff) >= bdq_pkg::CMP_W'(count_ff));
      if (kind_ff == bdq_pkg::K_POP_BACK) begin
         rd_idx = bdq_pkg::IDX_W'(count_ff - bdq_pkg::CNT_W'(1));
      end else if (kind_ff == bdq_pkg::K_REMOVE) begin
         rd_idx = bdq_pkg::IDX_W'(pos_ff);
      end else begin
         rd_idx = '0;
      end
      rd_data = entries_ff[rd_idx];
      for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
         match_vec[i] = (bdq_pkg::CNT_W'(i) < count_ff) && (entries_ff[i] == key_ff);
      end
   end

   // execute step: every cell picks its next value in parallel
   always_comb begin
      count_in   = count_ff;
      res_val_in = '0;
      status_in  = bdq_pkg::ST_OK;
      match_in   = '0;
      take       = 1'b0;
      for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      unique case (kind_ff)
         bdq_pkg::K_PUSH_BACK: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
                  if (bdq_pkg::IDX_W'(i) == bdq_pkg::IDX_W'(count_ff)) entries_in[i] = key_ff;
               end
               count_in = count_ff + bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::K_PUSH_FRONT: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               entries_in[0] = key_ff;
               for (int i = 1; i < bdq_pkg::DEPTH; i++) begin
                  entries_in[i] = entries_ff[i-1];
               end
               count_in = count_ff + bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::K_POP_BACK, bdq_pkg::K_POP_FRONT: begin
            if (empty) status_in = bdq_pkg::ST_EMPTY;
            else take = 1'b1;
         end
         bdq_pkg::K_REMOVE: begin
            if (empty) status_in = bdq_pkg::ST_EMPTY;
            else if (pos_bad) status_in = bdq_pkg::ST_BADPOS;
            else take = 1'b1;
         end
         bdq_pkg::K_FIND: begin
            match_in  = match_vec;
            status_in = bdq_pkg::ST_NOTFOUND;
         end
         default: begin
         end
      endcase
      if (take) begin
         res_val_in = rd_data;
         count_in   = count_ff - bdq_pkg::CNT_W'(1);
         // later entries close the gap
         for (int i = 0; i < bdq_pkg::DEPTH - 1; i++) begin
            if (bdq_pkg::IDX_W'(i) >= rd_idx) entries_in[i] = entries_ff[i+1];
         end
      end
   end

   // emit step: lowest matching cell wins
   always_comb begin
      find_idx = '0;
      for (int i = bdq_pkg::DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) find_idx = bdq_pkg::IDX_W'(i);
      end
      out_status_in = status_ff;
      if (|match_ff) out_status_in = bdq_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= bdq_pkg::kind_type'(req_kind);
         key_ff  <= bdq_pkg::VALUE_WIDTH'(req_item_value);
         pos_ff  <= req_position;
      end
      if (cmd.exec) begin
         for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
         res_val_ff <= res_val_in;
         status_ff  <= status_in;
         match_ff   <= match_in;
      end
      if (cmd.emit) begin
         out_value_ff  <= bdq_pkg::VAL_W'(res_val_ff);
         out_index_ff  <= bdq_pkg::INDEX_W'(find_idx);
         out_status_ff <= out_status_in;
         out_count_ff  <= bdq_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_out_value = out_value_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_count     = out_count_ff;

endmodule

// ===== hdl/bounded_deque_with_indexed_removal.sv =====
// top level of the bounded deque with indexed removal
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_kind, req_item_value, req_position
//  rsp      out        rsp_valid/rsp_ready   rsp_out_value, rsp_out_index, rsp_status, rsp_count
//
// one transaction at a time: capture, execute, emit, set by the three-state sequencer
// execute updates every cell in parallel; find registers its compare row, emit encodes it
// the result sits in an output register, so a new transaction is taken while it waits
// a stalled result only holds the sequencer in emit; reset is synchronous, active high
// reset empties the list at once: no clearing pass, the entry cells are not reset
module bounded_deque_with_indexed_removal (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bdq_pkg::KIND_W-1:0]      req_kind,
   input  logic [bdq_pkg::VAL_W-1:0]       req_item_value,
   input  logic [bdq_pkg::POS_W-1:0]       req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bdq_pkg::VAL_W-1:0]       rsp_out_value,
   output logic [bdq_pkg::INDEX_W-1:0]     rsp_out_index,
   output logic [bdq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]     rsp_count
);

   // commands from sequencer to datapath
   bdq_pkg::cmd_type cmd;

   // sequencer: owns the handshakes
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: list cells, count and result registers
   bdq_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_kind),
      .req_item_value (req_item_value),
      .req_position   (req_position),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_index  (rsp_out_index),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

endmodule

// ===== hdl/bdq_checker.sv =====
// port-level checks of the deque, bound to the top level
`include "bounded_deque_with_indexed_removal_assert.svh"

module bdq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bdq_pkg::VAL_W-1:0]       rsp_out_value,
   input logic [bdq_pkg::INDEX_W-1:0]     rsp_out_index,
   input logic [bdq_pkg::STATUS_W-1:0]    rsp_status,
   input logic [bdq_pkg::COUNT_W-1:0]     rsp_count
);

   `BDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_value) && $stable(rsp_out_index) && $stable(rsp_status) && $stable(rsp_count), "stalled result changed")
   `BDQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "transaction taken while busy")
   `BDQ_ASSERT_SAME(a_empty_count, rsp_valid && (rsp_status == bdq_pkg::ST_EMPTY), rsp_count == '0, "empty status with entries")
   `BDQ_ASSERT_SAME(a_full_count, rsp_valid && (rsp_status == bdq_pkg::ST_FULL), rsp_count == bdq_pkg::COUNT_W'(bdq_pkg::DEPTH), "full status below depth")
   `BDQ_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != bdq_pkg::ST_OK), (rsp_out_value == '0) && (rsp_out_index == '0), "failed result carries data")

endmodule

bind bounded_deque_with_indexed_removal bdq_checker u_bdq_checker (.*);
